// ----- src/sbfe_pkg.sv -----
// ----------------------------------------------------------------------------
// sbfe_pkg: shared types and constants of the stack bytecode evaluator
// Opcodes, status codes, state encodings and double-precision bit masks.
// ----------------------------------------------------------------------------
package sbfe_pkg;

	// Storage sizes.
	localparam int STACK_DEPTH = 256;
	localparam int POOL_DEPTH  = 1024;
	localparam int SA_W        = $clog2(STACK_DEPTH);
	localparam int SC_W        = SA_W + 1;
	localparam int PA_W        = $clog2(POOL_DEPTH);
	localparam int IDX_W       = 24;

	// Internal exponent width of the arithmetic unit (signed).
	localparam int FE_W = 14;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EXEC = 1'b1;

	typedef enum logic [2:0] {
		OP_CONST      = 3'd0,
		OP_CONST_LONG = 3'd1,
		OP_ADD        = 3'd2,
		OP_SUB        = 3'd3,
		OP_MUL        = 3'd4,
		OP_DIV        = 3'd5,
		OP_NEGATE     = 3'd6,
		OP_RETURN     = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PUSH,
		S_RD_B,
		S_RD_A,
		S_FPU,
		S_NEG,
		S_RET,
		S_EMIT
	} top_state_t;

	// Sequencer states of the arithmetic unit.
	typedef enum logic [3:0] {
		F_IDLE,
		F_ALIGN,
		F_ADD,
		F_MUL,
		F_PRE,
		F_DIV,
		F_DIVF,
		F_NORM,
		F_DENORM,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef struct packed {
		logic    start;
		opcode_t op;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} fpu_rsp_t;

	// Double-precision bit patterns.
	localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
	localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] QNAN_POS  = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] QNAN_NEG  = 64'hFFF8_0000_0000_0000;

endpackage

// ----- src/sbfe_item_if.sv -----
// ----------------------------------------------------------------------------
// sbfe_item_if: input channel of the evaluator
// Carries one load or execute command per transaction.
// ----------------------------------------------------------------------------
interface sbfe_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [2:0]  opcode;
	logic [23:0] const_index;
	logic [63:0] const_value;

	modport source (output valid, command, opcode, const_index, const_value, input ready);
	modport sink (input valid, command, opcode, const_index, const_value, output ready);
endinterface

// ----- src/sbfe_result_if.sv -----
// ----------------------------------------------------------------------------
// sbfe_result_if: result channel of the evaluator
// Carries one returned value or error status per transaction.
// ----------------------------------------------------------------------------
interface sbfe_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic [1:0]  status;

	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

// ----- src/sbfe_ram.sv -----
// ----------------------------------------------------------------------------
// sbfe_ram: generic single-write, single-read memory
// The read data is registered; it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sbfe_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- src/sbfe_fpu.sv -----
// ----------------------------------------------------------------------------
// sbfe_fpu: iterative double-precision add, subtract, multiply and divide
// One shared datapath: align and add, a 32x32 multiplier over four partial
// products, a restoring divider one quotient bit a cycle, a one-bit
// normalizing shifter, and a single round-to-nearest-even stage.
// ----------------------------------------------------------------------------
module sbfe_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  sbfe_pkg::fpu_req_t req,
	input  logic [63:0]        a,
	input  logic [63:0]        b,
	output sbfe_pkg::fpu_rsp_t rsp
);
	import sbfe_pkg::*;

	localparam logic signed [FE_W-1:0] E_ONE   = FE_W'(1);
	localparam logic signed [FE_W-1:0] E_MAX   = FE_W'(2047);
	localparam logic signed [FE_W-1:0] E_BIAS  = FE_W'(1023);
	localparam logic signed [FE_W-1:0] E_MULJ  = FE_W'(1022);
	localparam logic [5:0]             Q_LAST  = 6'd56;
	localparam logic [5:0]             MUL_END = 6'd4;

	fpu_state_t state_q, state_d;

	opcode_t                 op_q;
	logic                    sgn_q, sy_q, zs_q;
	logic signed [FE_W-1:0]  ea_q, eb_q, e_q;
	logic [53:0]             ma_q;
	logic [52:0]             mb_q;
	logic [127:0]            r_q, y_q;
	logic [63:0]             p_q, res_q;
	logic [1:0]              pk_q;
	logic [5:0]              cnt_q;

	// Operand classification and unpacking.
	logic                    a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, sx;
	logic signed [FE_W-1:0]  ea_u, eb_u;
	logic [52:0]             ma_u, mb_u;
	logic                    spec_hit, a_ge_b;
	logic [63:0]             spec_val;

	assign a_nan  = (&a[62:52]) && (|a[51:0]);
	assign b_nan  = (&b[62:52]) && (|b[51:0]);
	assign a_inf  = (&a[62:52]) && !(|a[51:0]);
	assign b_inf  = (&b[62:52]) && !(|b[51:0]);
	assign a_zero = (a[62:0] == 63'd0);
	assign b_zero = (b[62:0] == 63'd0);
	assign sbe    = b[63] ^ (req.op == OP_SUB);
	assign sx     = a[63] ^ b[63];
	assign ea_u   = (a[62:52] == 11'd0) ? E_ONE : {3'b000, a[62:52]};
	assign eb_u   = (b[62:52] == 11'd0) ? E_ONE : {3'b000, b[62:52]};
	assign ma_u   = {(a[62:52] != 11'd0), a[51:0]};
	assign mb_u   = {(b[62:52] != 11'd0), b[51:0]};
	assign a_ge_b = (a[62:0] >= b[62:0]);

	// NaN, infinity and zero operands that settle the result at once.
	always_comb begin
		spec_hit = 1'b1;
		spec_val = '0;
		if (a_nan) begin
			spec_val = a | QUIET_BIT;
		end else if (b_nan) begin
			spec_val = b | QUIET_BIT;
		end else begin
			case (req.op)
				OP_ADD, OP_SUB: begin
					if (a_inf && b_inf && (a[63] != sbe)) begin
						spec_val = QNAN_NEG;
					end else if (a_inf) begin
						spec_val = a;
					end else if (b_inf) begin
						spec_val = {sbe, b[62:0]};
					end else begin
						spec_hit = 1'b0;
					end
				end
				OP_MUL: begin
					if ((a_inf && b_zero) || (a_zero && b_inf)) begin
						spec_val = QNAN_NEG;
					end else if (a_inf || b_inf) begin
						spec_val = {sx, EXP_MASK[62:0]};
					end else if (a_zero || b_zero) begin
						spec_val = {sx, 63'd0};
					end else begin
						spec_hit = 1'b0;
					end
				end
				default: begin
					if (b_zero) begin
						spec_val = a_zero ? QNAN_POS : {sx, EXP_MASK[62:0]};
					end else if (a_inf && b_inf) begin
						spec_val = QNAN_NEG;
					end else if (a_inf) begin
						spec_val = {sx, EXP_MASK[62:0]};
					end else if (b_inf || a_zero) begin
						spec_val = {sx, 63'd0};
					end else begin
						spec_hit = 1'b0;
					end
				end
			endcase
		end
	end

	// Alignment shift of the smaller addend, with sticky collection.
	logic signed [FE_W-1:0] d_al;
	logic [127:0]           y_full, y_sh, y_al;
	logic                   y_lost;

	assign d_al   = ea_q - eb_q;
	assign y_full = {1'b0, mb_q, 74'd0};
	assign y_sh   = y_full >> d_al[6:0];
	assign y_lost = ((y_sh << d_al[6:0]) != y_full);
	assign y_al   = (|d_al[FE_W-1:7]) ? {127'd0, (|mb_q)} : (y_sh | {127'd0, y_lost});

	// Add or subtract the aligned significands.
	logic [127:0] x_full, sum;

	assign x_full = {1'b0, ma_q[52:0], 74'd0};
	assign sum    = (sgn_q == sy_q) ? (x_full + y_q) : (x_full - y_q);

	// Shared multiplier: one 32x32 partial product a cycle.
	logic [31:0]  mul_x, mul_y;
	logic [63:0]  prod;
	logic [6:0]   pshift;

	assign mul_x = cnt_q[1] ? {11'd0, ma_q[52:32]} : ma_q[31:0];
	assign mul_y = cnt_q[0] ? {11'd0, mb_q[52:32]} : mb_q[31:0];
	assign prod  = mul_x * mul_y;

	always_comb begin
		case (pk_q)
			2'd0:    pshift = 7'd22;
			2'd3:    pshift = 7'd86;
			default: pshift = 7'd54;
		endcase
	end

	// Restoring divide step.
	logic        div_ge;
	logic [53:0] div_rem;

	assign div_ge  = (ma_q >= {1'b0, mb_q});
	assign div_rem = ma_q - (div_ge ? {1'b0, mb_q} : 54'd0);

	// Right shift into the subnormal range.
	logic signed [FE_W-1:0] d_dn;
	logic [127:0]           r_sh, r_dn;
	logic                   r_lost;

	assign d_dn   = E_ONE - e_q;
	assign r_sh   = r_q >> d_dn[6:0];
	assign r_lost = ((r_sh << d_dn[6:0]) != r_q);
	assign r_dn   = (|d_dn[FE_W-1:7]) ? {127'd0, (|r_q)} : (r_sh | {127'd0, r_lost});

	// Round to nearest even and pack.
	logic [52:0]            m53, mant;
	logic [53:0]            m_rnd;
	logic                   rnd_up;
	logic signed [FE_W-1:0] e_rnd;
	logic [63:0]            rnd_val;

	assign m53    = r_q[127:75];
	assign rnd_up = r_q[74] && ((|r_q[73:0]) || m53[0]);
	assign m_rnd  = {1'b0, m53} + {53'd0, rnd_up};
	assign mant   = m_rnd[53] ? m_rnd[53:1] : m_rnd[52:0];
	assign e_rnd  = m_rnd[53] ? (e_q + E_ONE) : e_q;
	assign rnd_val = (e_rnd >= E_MAX) ? {sgn_q, EXP_MASK[62:0]}
		: {sgn_q, (mant[52] ? e_rnd[10:0] : 11'd0), mant[51:0]};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					if (spec_hit) begin
						state_d = F_DONE;
					end else if (req.op == OP_ADD || req.op == OP_SUB) begin
						state_d = F_ALIGN;
					end else if (req.op == OP_MUL) begin
						state_d = F_MUL;
					end else begin
						state_d = F_PRE;
					end
				end
			end
			F_ALIGN:  state_d = F_ADD;
			F_ADD:    state_d = (sum == 128'd0) ? F_DONE : F_NORM;
			F_MUL: begin
				if (cnt_q == MUL_END) begin
					state_d = F_NORM;
				end
			end
			F_PRE: begin
				if (ma_q[52] && mb_q[52]) begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				if (cnt_q == Q_LAST) begin
					state_d = F_DIVF;
				end
			end
			F_DIVF:   state_d = F_NORM;
			F_NORM: begin
				if (r_q[127]) begin
					state_d = F_DENORM;
				end
			end
			F_DENORM: state_d = F_ROUND;
			F_ROUND:  state_d = F_DONE;
			F_DONE:   state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				op_q  <= req.op;
				res_q <= spec_val;
				cnt_q <= '0;
				r_q   <= '0;
				zs_q  <= a[63] & sbe;
				if ((req.op == OP_ADD || req.op == OP_SUB) && !a_ge_b) begin
					ma_q  <= {1'b0, mb_u};
					ea_q  <= eb_u;
					mb_q  <= ma_u;
					eb_q  <= ea_u;
					sgn_q <= sbe;
					sy_q  <= a[63];
				end else begin
					ma_q  <= {1'b0, ma_u};
					ea_q  <= ea_u;
					mb_q  <= mb_u;
					eb_q  <= eb_u;
					sgn_q <= (req.op == OP_ADD || req.op == OP_SUB) ? a[63] : sx;
					sy_q  <= sbe;
				end
				e_q <= ea_u + eb_u - E_MULJ;
			end
			F_ALIGN: begin
				y_q <= y_al;
			end
			F_ADD: begin
				r_q   <= sum;
				e_q   <= ea_q + E_ONE;
				res_q <= {zs_q, 63'd0};
			end
			F_MUL: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q != MUL_END) begin
					p_q  <= prod;
					pk_q <= cnt_q[1:0];
				end
				if (cnt_q != 6'd0) begin
					r_q <= r_q + ({64'd0, p_q} << pshift);
				end
			end
			F_PRE: begin
				if (!ma_q[52]) begin
					ma_q <= {ma_q[52:0], 1'b0};
					ea_q <= ea_q - E_ONE;
				end else if (!mb_q[52]) begin
					mb_q <= {mb_q[51:0], 1'b0};
					eb_q <= eb_q - E_ONE;
				end
				e_q <= ea_q - eb_q + E_BIAS;
			end
			F_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				ma_q  <= {div_rem[52:0], 1'b0};
				r_q   <= {r_q[126:0], div_ge};
			end
			F_DIVF: begin
				r_q <= {r_q[56:0], 70'd0, (ma_q != 54'd0)};
			end
			F_NORM: begin
				if (!r_q[127]) begin
					r_q <= {r_q[126:0], 1'b0};
					e_q <= e_q - E_ONE;
				end
			end
			F_DENORM: begin
				if (e_q < E_ONE) begin
					r_q <= r_dn;
					e_q <= E_ONE;
				end
			end
			F_ROUND: begin
				res_q <= rnd_val;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done  = (state_q == F_DONE);
	assign rsp.value = res_q;
endmodule

// ----- src/stack_bytecode_float_evaluator.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_float_evaluator: stack machine for double-precision bytecode
// Loads a constant pool, runs push, arithmetic, negate and return commands
// against a value stack, and reports returned values and error status.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  item     in         command, opcode, const_index, const_value
//  result   out        result_value, status
//
//  One command at a time; item.ready is high only while the sequencer idles.
//  Add/sub/mul normalize through a one-bit shifter: a result that cancels or
//  lands in the subnormal range is shifted one bit per cycle. Divide develops
//  57 quotient bits, one per cycle, after shifting a subnormal operand one
//  leading zero per cycle. Reset empties the stack; memories are not cleared.
//  A result waits in the output register; the block stalls only when a new
//  result finds that register still full.
//
module stack_bytecode_float_evaluator (
	input logic          clk,
	input logic          arst_n,
	sbfe_item_if.sink    item,
	sbfe_result_if.source result
);
	import sbfe_pkg::*;

	top_state_t state_q, state_d;

	logic              cmd_q;
	opcode_t           op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [63:0]       val_q, b_q;
	logic [SC_W-1:0]   depth_q, depth_d;
	logic [63:0]       res_val_q, res_val_d;
	status_t           res_st_q, res_st_d;
	logic              res_ld;
	logic              out_valid_q, out_ld;
	logic [63:0]       out_value_q;
	status_t           out_status_q;

	logic              stk_we, pool_we;
	logic [SA_W-1:0]   stk_waddr, stk_raddr;
	logic [63:0]       stk_wdata, stk_rdata, pool_rdata;
	logic [PA_W-1:0]   pool_raddr;

	fpu_req_t          fpu_req;
	fpu_rsp_t          fpu_rsp;

	// Index checks and stack pointers.
	logic [IDX_W-1:0]  idx_eff;
	logic              push_ok, load_ok;
	logic [SC_W-1:0]   dm1, dm2;

	assign idx_eff    = (op_q == OP_CONST) ? {16'd0, idx_q[7:0]} : idx_q;
	assign push_ok    = ({1'b0, idx_eff} < (IDX_W + 1)'(POOL_DEPTH));
	assign load_ok    = ({1'b0, idx_q} < (IDX_W + 1)'(POOL_DEPTH));
	assign dm1        = depth_q - SC_W'(1);
	assign dm2        = depth_q - SC_W'(2);
	assign pool_raddr = idx_eff[PA_W-1:0];

	sbfe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(64)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	sbfe_ram #(.DEPTH(POOL_DEPTH), .WIDTH(64)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (idx_q[PA_W-1:0]),
		.wdata (val_q),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	sbfe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.a      (stk_rdata),
		.b      (b_q),
		.rsp    (fpu_rsp)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			cmd_q <= item.command;
			op_q  <= opcode_t'(item.opcode);
			idx_q <= item.const_index;
			val_q <= item.const_value;
		end
		if (state_q == S_RD_B) begin
			b_q <= stk_rdata;
		end
		if (res_ld) begin
			res_val_q <= res_val_d;
			res_st_q  <= res_st_d;
		end
		if (out_ld) begin
			out_value_q  <= res_val_q;
			out_status_q <= res_st_q;
		end
	end

	// Sequencer.
	always_comb begin
		state_d       = state_q;
		depth_d       = depth_q;
		stk_we        = 1'b0;
		stk_waddr     = dm1[SA_W-1:0];
		stk_wdata     = stk_rdata ^ SIGN_BIT;
		stk_raddr     = dm1[SA_W-1:0];
		pool_we       = 1'b0;
		fpu_req.start = 1'b0;
		fpu_req.op    = op_q;
		res_ld        = 1'b0;
		res_val_d     = '0;
		res_st_d      = ST_OK;
		out_ld        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (cmd_q == CMD_LOAD) begin
					if (load_ok) begin
						pool_we = 1'b1;
						state_d = S_IDLE;
					end else begin
						res_ld   = 1'b1;
						res_st_d = ST_RANGE;
						state_d  = S_EMIT;
					end
				end else begin
					case (op_q)
						OP_CONST, OP_CONST_LONG: begin
							res_ld = 1'b1;
							if (!push_ok) begin
								res_st_d = ST_RANGE;
								state_d  = S_EMIT;
							end else if (depth_q == SC_W'(STACK_DEPTH)) begin
								res_st_d = ST_OVER;
								state_d  = S_EMIT;
							end else begin
								res_ld  = 1'b0;
								state_d = S_PUSH;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (depth_q < SC_W'(2)) begin
								res_ld   = 1'b1;
								res_st_d = ST_UNDER;
								state_d  = S_EMIT;
							end else begin
								state_d = S_RD_B;
							end
						end
						OP_NEGATE: begin
							if (depth_q == '0) begin
								res_ld   = 1'b1;
								res_st_d = ST_UNDER;
								state_d  = S_EMIT;
							end else begin
								state_d = S_NEG;
							end
						end
						default: begin
							if (depth_q == '0) begin
								res_ld   = 1'b1;
								res_st_d = ST_UNDER;
								state_d  = S_EMIT;
							end else begin
								state_d = S_RET;
							end
						end
					endcase
				end
			end
			S_PUSH: begin
				stk_we    = 1'b1;
				stk_waddr = depth_q[SA_W-1:0];
				stk_wdata = pool_rdata;
				depth_d   = depth_q + SC_W'(1);
				state_d   = S_IDLE;
			end
			S_RD_B: begin
				stk_raddr = dm2[SA_W-1:0];
				state_d   = S_RD_A;
			end
			S_RD_A: begin
				fpu_req.start = 1'b1;
				state_d       = S_FPU;
			end
			S_FPU: begin
				if (fpu_rsp.done) begin
					stk_we    = 1'b1;
					stk_waddr = dm2[SA_W-1:0];
					stk_wdata = fpu_rsp.value;
					depth_d   = dm1;
					state_d   = S_IDLE;
				end
			end
			S_NEG: begin
				stk_we  = 1'b1;
				state_d = S_IDLE;
			end
			S_RET: begin
				res_ld    = 1'b1;
				res_val_d = stk_rdata;
				res_st_d  = ST_OK;
				depth_d   = '0;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || result.ready) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.result_value = out_value_q;
	assign result.status       = out_status_q;

`ifndef ASSERT_OFF
	// The stack never holds more entries than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SC_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// A return leaves the stack empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RET |=> depth_q == '0)
		else $error("stack not emptied by return");

	// A finished binary operation pops exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FPU && fpu_rsp.done) |=> depth_q == $past(depth_q) - SC_W'(1))
		else $error("binary operation did not pop one entry");

	// The arithmetic unit reports completion only while the sequencer waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> state_q == S_FPU)
		else $error("arithmetic result with no operation pending");
`endif
endmodule

// ----- bench/stack_bytecode_float_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_float_evaluator_tb: self-checking bench of the evaluator
// Replays a table of directed commands, then random bytecode programs, noise
// and a stack overflow burst. A double-precision stack predictor computes each
// expected return value or error status, which is compared with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_bytecode_float_evaluator_tb;
	import sbfe_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;

	// One command as driven on the input channel.
	typedef struct {
		logic        cmd;
		opcode_t     op;
		logic [23:0] idx;
		logic [63:0] val;
		bit          chk;
		status_t     st;
		logic [63:0] rv;
	} cmd_row_t;

	typedef struct {
		logic [63:0] rv;
		status_t     st;
	} outcome_t;

	logic clk;
	logic arst_n;

	sbfe_item_if   item_ch ();
	sbfe_result_if res_ch ();

	stack_bytecode_float_evaluator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	// Predictor state: value stack, depth and constant pool.
	logic [63:0] pred_stack [STACK_DEPTH];
	int          pred_depth;
	logic [63:0] pred_pool [POOL_DEPTH];
	bit          pool_loaded [POOL_DEPTH];
	int          loaded_low [$];
	int          loaded_all [$];

	outcome_t pending_results [$];
	int       fail_count;
	int       cycle_count;
	int       hold_request;
	bit       steady_flow;
	int       sent_count;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic [63:0] div_bits(input logic [63:0] a, input logic [63:0] b);
		bit a_nan;
		a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
		if (b[62:0] == 0) begin
			if (a_nan)
				return a | QUIET_BIT;
			if (a[62:0] == 0)
				return QNAN_POS;
			return EXP_MASK | ((a ^ b) & SIGN_BIT);
		end
		return $realtobits($bitstoreal(a) / $bitstoreal(b));
	endfunction

	// Applies one accepted command to the predictor; reports any result.
	function automatic bit evaluate(input cmd_row_t c, output outcome_t o);
		int          pidx;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		o.rv = '0;
		o.st = ST_OK;
		if (c.cmd == CMD_LOAD) begin
			if (c.idx >= POOL_DEPTH) begin
				o.st = ST_RANGE;
				return 1'b1;
			end
			pred_pool[c.idx] = c.val;
			if (!pool_loaded[c.idx]) begin
				pool_loaded[c.idx] = 1'b1;
				loaded_all.push_back(int'(c.idx));
				if (c.idx < 256)
					loaded_low.push_back(int'(c.idx));
			end
			return 1'b0;
		end
		case (c.op)
			OP_CONST, OP_CONST_LONG: begin
				pidx = (c.op == OP_CONST) ? int'(c.idx[7:0]) : int'(c.idx);
				if (pidx >= POOL_DEPTH) begin
					o.st = ST_RANGE;
					return 1'b1;
				end
				if (pred_depth >= STACK_DEPTH) begin
					o.st = ST_OVER;
					return 1'b1;
				end
				pred_stack[pred_depth] = pred_pool[pidx];
				pred_depth++;
				return 1'b0;
			end
			OP_NEGATE: begin
				if (pred_depth < 1) begin
					o.st = ST_UNDER;
					return 1'b1;
				end
				pred_stack[pred_depth - 1] ^= SIGN_BIT;
				return 1'b0;
			end
			OP_RETURN: begin
				if (pred_depth < 1) begin
					o.st = ST_UNDER;
					return 1'b1;
				end
				o.rv = pred_stack[pred_depth - 1];
				pred_depth = 0;
				return 1'b1;
			end
			default: begin
				if (pred_depth < 2) begin
					o.st = ST_UNDER;
					return 1'b1;
				end
				a = pred_stack[pred_depth - 2];
				b = pred_stack[pred_depth - 1];
				case (c.op)
					OP_ADD: r = $realtobits($bitstoreal(a) + $bitstoreal(b));
					OP_SUB: r = $realtobits($bitstoreal(a) - $bitstoreal(b));
					OP_MUL: r = $realtobits($bitstoreal(a) * $bitstoreal(b));
					default: r = div_bits(a, b);
				endcase
				pred_depth--;
				pred_stack[pred_depth - 1] = r;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic cmd_row_t mk(input logic cmd, input opcode_t op, input logic [23:0] idx,
		input logic [63:0] val, input bit chk = 1'b0, input status_t st = ST_OK,
		input logic [63:0] rv = '0);
		cmd_row_t c;
		c.cmd = cmd;
		c.op  = op;
		c.idx = idx;
		c.val = val;
		c.chk = chk;
		c.st  = st;
		c.rv  = rv;
		return c;
	endfunction

	function automatic int pick_gap();
		if (steady_flow || $urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drives one command and waits for it to be accepted.
	task automatic send(input cmd_row_t c);
		int       gap;
		outcome_t o;
		bit       has;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.command     <= c.cmd;
		item_ch.opcode      <= c.op;
		item_ch.const_index <= c.idx;
		item_ch.const_value <= c.val;
		do @(posedge clk); while (!item_ch.ready);
		has = evaluate(c, o);
		if (c.chk && (!has || o.st != c.st || o.rv != c.rv)) begin
			$error("table row %0d: predicted status %0d value %h, listed %0d %h",
				sent_count, o.st, o.rv, c.st, c.rv);
			fail_count++;
		end
		if (has)
			pending_results.push_back(o);
		sent_count++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_double();
		case ($urandom_range(0, 11))
			0: return 64'h0;
			1: return SIGN_BIT;
			2: return EXP_MASK | (SIGN_BIT & {$urandom, $urandom});
			3: return {$urandom, $urandom} | EXP_MASK;
			4: return {$urandom_range(0, 1) == 1, 11'h0, $urandom_range(0, 1023),
				$urandom} & 64'h800F_FFFF_FFFF_FFFF;
			5: return 64'h7FEF_FFFF_FFFF_FFFF ^ (SIGN_BIT & {$urandom, $urandom});
			6: return {$urandom, $urandom};
			default: return {1'($urandom), 11'($urandom_range(1003, 1043)), 20'($urandom),
				$urandom};
		endcase
	endfunction

	function automatic logic [23:0] loaded_index(input bit low);
		if (low)
			return 24'(loaded_low[$urandom_range(0, loaded_low.size() - 1)]);
		return 24'(loaded_all[$urandom_range(0, loaded_all.size() - 1)]);
	endfunction

	// A random command that never reads an unloaded pool entry.
	function automatic cmd_row_t noise_cmd();
		cmd_row_t c;
		c = mk(1'($urandom), opcode_t'($urandom_range(0, 7)), 24'($urandom), rand_double());
		if ($urandom_range(0, 3) == 0)
			c.idx = 24'($urandom_range(0, 1023));
		if (c.cmd == CMD_EXEC && c.op == OP_CONST && !pool_loaded[c.idx[7:0]])
			c.idx[7:0] = loaded_index(1'b1);
		if (c.cmd == CMD_EXEC && c.op == OP_CONST_LONG && c.idx < POOL_DEPTH &&
				!pool_loaded[c.idx])
			c.idx = loaded_index(1'b0);
		return c;
	endfunction

	// A well-formed program: a few loads, pushes and operations, then return.
	task automatic run_program();
		int       depth;
		int       steps;
		cmd_row_t c;
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 7) == 0)
				send(mk(CMD_LOAD, OP_CONST, 24'($urandom_range(1024, 24'hFFFFFF)), rand_double()));
			else
				send(mk(CMD_LOAD, OP_CONST, 24'($urandom_range(0, 1023)), rand_double()));
		end
		depth = 0;
		steps = $urandom_range(1, 10);
		for (int s = 0; s < steps; s++) begin
			if (depth < 2 || $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 1) == 0)
					c = mk(CMD_EXEC, OP_CONST,
						{16'($urandom), loaded_index(1'b1)[7:0]}, 64'($urandom));
				else
					c = mk(CMD_EXEC, OP_CONST_LONG, loaded_index(1'b0), 64'($urandom));
				depth++;
			end else if ($urandom_range(0, 5) == 0) begin
				c = mk(CMD_EXEC, OP_NEGATE, 24'($urandom), 64'($urandom));
			end else begin
				c = mk(CMD_EXEC, opcode_t'($urandom_range(OP_ADD, OP_DIV)), 24'($urandom),
					64'($urandom));
				depth--;
			end
			send(c);
		end
		send(mk(CMD_EXEC, OP_RETURN, 24'($urandom), 64'($urandom)));
	endtask

	// Result channel: random back-pressure plus long hold-offs on request.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				res_ch.ready <= 1'b0;
				hold_request--;
			end else if (steady_flow || $urandom_range(0, 9) < 6) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				hold_request = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
					: $urandom_range(10, 40);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d value %h",
					res_ch.status, res_ch.result_value);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (res_ch.status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, res_ch.status);
					fail_count++;
				end
				if (res_ch.result_value !== e.rv) begin
					$error("result_value: expected %h, actual %h", e.rv, res_ch.result_value);
					fail_count++;
				end
			end
		end
	end

	// Stimulus.
	initial begin
		cmd_row_t table_rows [$];
		item_ch.valid       = 1'b0;
		item_ch.command     = CMD_LOAD;
		item_ch.opcode      = OP_CONST;
		item_ch.const_index = '0;
		item_ch.const_value = '0;
		arst_n       = 1'b0;
		fail_count   = 0;
		hold_request = 0;
		steady_flow  = 1'b0;
		sent_count   = 0;
		pred_depth   = 0;
		foreach (pool_loaded[i])
			pool_loaded[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty-stack errors, pool range, signs and zero division.
		table_rows.push_back(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0, 1, ST_UNDER));
		table_rows.push_back(mk(CMD_EXEC, OP_ADD, 24'h0, 64'h0, 1, ST_UNDER));
		table_rows.push_back(mk(CMD_EXEC, OP_NEGATE, 24'h0, 64'h0, 1, ST_UNDER));
		table_rows.push_back(mk(CMD_LOAD, OP_CONST, 24'd1024, 64'h1, 1, ST_RANGE));
		table_rows.push_back(mk(CMD_LOAD, OP_RETURN, 24'hFFFFFF, '1, 1, ST_RANGE));
		table_rows.push_back(mk(CMD_LOAD, OP_CONST, 24'd0, 64'h3FF0_0000_0000_0000));
		table_rows.push_back(mk(CMD_LOAD, OP_CONST, 24'd1023, '1));
		table_rows.push_back(mk(CMD_LOAD, OP_CONST, 24'd1, 64'h0));
		table_rows.push_back(mk(CMD_LOAD, OP_CONST, 24'd2, SIGN_BIT));
		table_rows.push_back(mk(CMD_EXEC, OP_CONST, 24'hFFFF00, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0, 1, ST_OK,
			64'h3FF0_0000_0000_0000));
		table_rows.push_back(mk(CMD_EXEC, OP_CONST_LONG, 24'h0003FF, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_NEGATE, 24'h0, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_CONST_LONG, 24'd1024, 64'h0, 1, ST_RANGE));
		table_rows.push_back(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0, 1, ST_OK,
			64'h7FFF_FFFF_FFFF_FFFF));
		// One divided by positive zero, zero by negative zero, then a multiply on one entry.
		table_rows.push_back(mk(CMD_EXEC, OP_CONST, 24'd0, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_CONST, 24'd1, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_DIV, 24'h0, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0, 1, ST_OK, EXP_MASK));
		table_rows.push_back(mk(CMD_EXEC, OP_CONST, 24'd1, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_CONST, 24'd2, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_DIV, 24'h0, 64'h0));
		table_rows.push_back(mk(CMD_EXEC, OP_MUL, 24'h0, 64'h0, 1, ST_UNDER));
		table_rows.push_back(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0, 1, ST_OK, QNAN_POS));
		foreach (table_rows[i])
			send(table_rows[i]);
		// Arithmetic on the extremes, checked by the predictor only.
		send(mk(CMD_EXEC, OP_CONST, 24'd0, 64'h0));
		send(mk(CMD_EXEC, OP_CONST_LONG, 24'd1023, 64'h0));
		send(mk(CMD_EXEC, OP_SUB, 24'h0, 64'h0));
		send(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0));
		drain();

		// Fill the low pool with random doubles.
		for (int i = 0; i < 24; i++)
			send(mk(CMD_LOAD, OP_CONST, 24'($urandom_range(3, 255)), rand_double()));

		// Random programs with noise in between.
		for (int n = 0; n < 100; n++) begin
			steady_flow = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) send(noise_cmd());
			else
				run_program();
		end
		steady_flow = 1'b0;

		// Receiver holds off while errors pile up, then the sender waits it out.
		drain();
		hold_request = 400;
		repeat (20) send(mk(CMD_EXEC, OP_RETURN, 24'($urandom), 64'($urandom)));
		drain();

		// Overflow: push past a full stack, then add and return.
		repeat (STACK_DEPTH + 3)
			send(mk(CMD_EXEC, OP_CONST, {16'h0, loaded_index(1'b1)[7:0]}, 64'h0));
		send(mk(CMD_EXEC, OP_ADD, 24'h0, 64'h0));
		send(mk(CMD_EXEC, OP_RETURN, 24'h0, 64'h0));

		for (int n = 0; n < 80; n++) begin
			if ($urandom_range(0, 3) == 0)
				send(noise_cmd());
			else
				run_program();
		end

		// Wind down.
		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
